FILE: design/blpd_pkg.sv
// ----------------------------------------------------------------------------
// blpd_pkg
// Shared types and constants of the Bezier lattice point deformation block.
// ----------------------------------------------------------------------------
package blpd_pkg;

	// lattice geometry
	localparam int MAX_ORDER = 4;
	localparam int ORD_W     = 3;
	localparam int IDX_W     = 6;
	localparam int K_W       = 2;

	// fixed point: parameters are Q2.16, weights Q16
	localparam int PAR_W  = 19;
	localparam int BW     = 24;
	localparam int Q_FRAC = 16;
	localparam logic signed [PAR_W-1:0] T_LO  = -19'sd1;
	localparam logic signed [PAR_W-1:0] T_HI  = 19'sd65537;
	localparam logic signed [BW-1:0]    Q_ONE = 24'sd65536;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_ORDER_U   = 2'd0,
		CFG_ORDER_V   = 2'd1,
		CFG_ORDER_W   = 2'd2,
		CFG_TRILINEAR = 2'd3
	} cfg_idx_t;

	typedef enum logic {
		CMD_WRITE = 1'b0,
		CMD_EVAL  = 1'b1
	} cmd_t;

	typedef struct packed {
		logic [ORD_W-1:0] order_u;
		logic [ORD_W-1:0] order_v;
		logic [ORD_W-1:0] order_w;
		logic             trilinear;
	} cfg_t;

	// classification of a queued word
	typedef struct packed {
		cmd_t             cmd;
		logic             in_cube;
		logic             last;
		logic [IDX_W-1:0] idx;
	} cls_t;

	// back-end sequencer
	typedef enum logic [4:0] {
		S_IDLE,
		S_LOAD,
		S_BP,
		S_BS,
		S_BWAIT,
		S_BB,
		S_AXNEXT,
		S_TF,
		S_TFWAIT,
		S_VW,
		S_VWWAIT,
		S_WT,
		S_WTWAIT,
		S_MX,
		S_MY,
		S_MZ,
		S_DRAIN,
		S_OUT
	} seq_t;

	// destination of a product, written back in the cycle after its issue
	typedef enum logic [3:0] {
		T_NONE,
		T_PT,
		T_PS,
		T_B,
		T_F,
		T_WVW,
		T_WT,
		T_AX,
		T_AY,
		T_AZ
	} tag_t;

	// degree of an axis: order-1, with order 0 taken as 1 and large orders clamped
	function automatic logic [K_W-1:0] eff_n(input logic [ORD_W-1:0] o);
		logic [K_W-1:0] n;
		case (o)
			3'd0, 3'd1: n = 2'd0;
			3'd2:       n = 2'd1;
			3'd3:       n = 2'd2;
			default:    n = 2'd3;
		endcase
		return n;
	endfunction

	// binomial coefficient C(n,k) for n up to 3
	function automatic logic [1:0] binom(input logic [K_W-1:0] n, input logic [K_W-1:0] k);
		logic [1:0] c;
		c = 2'd1;
		if (k != 2'd0 && k != n) begin
			c = (n == 2'd3) ? 2'd3 : 2'd2;
		end
		return c;
	endfunction

endpackage

FILE: design/blpd_front.sv
// ----------------------------------------------------------------------------
// blpd_front
// Accepts stream words, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module blpd_front #(
	parameter int CW = 32,
	localparam int IN_W = ((6 + 6 * CW + 3 * 19) + 7) / 8 * 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_valid,
	output logic                             s_ready,
	input  logic [IN_W-1:0]                  s_data,
	input  logic                             s_cmd,
	input  logic                             s_last,
	output logic                             q_valid,
	input  logic                             q_pop,
	output blpd_pkg::cls_t                   q_cls,
	output logic [3*blpd_pkg::PAR_W-1:0]     q_par,
	output logic [3*CW-1:0]                  q_pt
);
	import blpd_pkg::*;

	localparam int CTRL_LO = IDX_W;
	localparam int PAR_LO  = IDX_W + 3 * CW;
	localparam int ORIG_LO = PAR_LO + 3 * PAR_W;

	logic signed [PAR_W-1:0] pu, pv, pw;
	logic                    in_cube;
	cls_t                    cls_in;
	logic [3*CW-1:0]         pt_in;

	cls_t                    ent_cls_q [2];
	logic [3*PAR_W-1:0]      ent_par_q [2];
	logic [3*CW-1:0]         ent_pt_q  [2];
	logic                    wp_q, rp_q;
	logic [1:0]              cnt_q;
	logic                    push;

	// unit cube test on all three lattice parameters
	assign pu = $signed(s_data[PAR_LO +: PAR_W]);
	assign pv = $signed(s_data[PAR_LO + PAR_W +: PAR_W]);
	assign pw = $signed(s_data[PAR_LO + 2 * PAR_W +: PAR_W]);
	assign in_cube = (pu >= T_LO) && (pu <= T_HI) && (pv >= T_LO) && (pv <= T_HI) &&
		(pw >= T_LO) && (pw <= T_HI);

	// writes carry the control point, evaluates the original point
	always_comb begin
		cls_in.cmd     = cmd_t'(s_cmd);
		cls_in.in_cube = in_cube;
		cls_in.last    = s_last;
		cls_in.idx     = s_data[IDX_W-1:0];
		pt_in = (cls_in.cmd == CMD_WRITE) ? s_data[CTRL_LO +: 3 * CW] : s_data[ORIG_LO +: 3 * CW];
	end

	assign s_ready = (cnt_q != 2'd2);
	assign push    = s_valid && s_ready;
	assign q_valid = (cnt_q != 2'd0);
	assign q_cls   = ent_cls_q[rp_q];
	assign q_par   = ent_par_q[rp_q];
	assign q_pt    = ent_pt_q[rp_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			ent_cls_q[wp_q] <= cls_in;
			ent_par_q[wp_q] <= s_data[PAR_LO +: 3 * PAR_W];
			ent_pt_q[wp_q]  <= pt_in;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (q_pop) begin
				rp_q <= ~rp_q;
			end
			if (push && !q_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (!push && q_pop) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

FILE: design/blpd_back.sv
// ----------------------------------------------------------------------------
// blpd_back
// Lattice store and sequencer around one shared multiplier: basis setup,
// weight products and multiply-accumulate of the control points.
// ----------------------------------------------------------------------------
module blpd_back #(
	parameter int CW = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  blpd_pkg::cfg_t               cfg,
	input  logic                         q_valid,
	output logic                         q_pop,
	input  blpd_pkg::cls_t               q_cls,
	input  logic [3*blpd_pkg::PAR_W-1:0] q_par,
	input  logic [3*CW-1:0]              q_pt,
	output logic                         m_valid,
	input  logic                         m_ready,
	output logic [3*CW-1:0]              m_data,
	output logic                         m_deformed,
	output logic                         m_last
);
	import blpd_pkg::*;

	localparam int MW    = (CW > BW) ? CW : BW;
	localparam int PW    = MW + BW;
	localparam int AW    = PW + 6;
	localparam int LAT_D = MAX_ORDER * MAX_ORDER * MAX_ORDER;
	localparam logic signed [PW-1:0] P_HALF = PW'(32768);
	localparam logic signed [AW-1:0] A_HALF = AW'(32768);

	seq_t st_q, st_d;

	// current item
	cls_t                    cls_q;
	logic signed [PAR_W-1:0] u_q, v_q, w_q;
	logic [3*CW-1:0]         pt3_q;

	// loop counters
	logic [1:0]       ax_q;
	logic [K_W-1:0]   k_q, ku_q, kv_q, kw_q;
	logic [IDX_W-1:0] idx_q;

	// basis and weight registers
	logic signed [BW-1:0] pt_q [MAX_ORDER];
	logic signed [BW-1:0] ps_q [MAX_ORDER];
	logic signed [BW-1:0] b_q  [3][MAX_ORDER];
	logic signed [BW-1:0] f_q  [4];
	logic signed [BW-1:0] wvw_q, wt_q;
	logic signed [AW-1:0] acc_q [3];

	// multiplier
	logic signed [MW-1:0] mul_a;
	logic signed [BW-1:0] mul_b;
	logic signed [PW-1:0] mul_p, prod_q;
	tag_t                 mul_tag, tag_q;
	logic [1:0]           mul_c, tc_q;
	logic [K_W-1:0]       tk_q;
	logic [1:0]           tax_q;
	logic signed [PW-1:0] rnd_w;
	logic signed [BW-1:0] rnd_b, b_val;

	// lattice store
	logic [3*CW-1:0] lat_mem [LAT_D];
	logic [3*CW-1:0] rd_q;

	logic [K_W-1:0]       nu, nv, nw, n_ax, n_next;
	logic signed [BW-1:0] t_ax, s_ax, u24, v24, w24, su, sv, sw;
	logic [3*CW-1:0]      fin;
	logic                 out_load;

	assign nu = eff_n(cfg.order_u);
	assign nv = eff_n(cfg.order_v);
	assign nw = eff_n(cfg.order_w);

	assign u24 = BW'(u_q);
	assign v24 = BW'(v_q);
	assign w24 = BW'(w_q);
	assign su  = Q_ONE - u24;
	assign sv  = Q_ONE - v24;
	assign sw  = Q_ONE - w24;

	// per-axis degree and parameter
	always_comb begin
		case (ax_q)
			2'd0: begin
				n_ax = nu;
				t_ax = u24;
			end
			2'd1: begin
				n_ax = nv;
				t_ax = v24;
			end
			default: begin
				n_ax = nw;
				t_ax = w24;
			end
		endcase
		n_next = (ax_q == 2'd0) ? nv : nw;
	end
	assign s_ax = Q_ONE - t_ax;

	assign out_load = (st_q == S_OUT) && (!m_valid || m_ready);

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			S_IDLE: begin
				if (q_valid) st_d = S_LOAD;
			end
			S_LOAD: begin
				if (cls_q.cmd == CMD_WRITE) st_d = S_IDLE;
				else if (!cls_q.in_cube) st_d = S_OUT;
				else if (cfg.trilinear) st_d = S_TF;
				else if (nu == '0) st_d = S_BWAIT;
				else st_d = S_BP;
			end
			S_BP:    st_d = S_BS;
			S_BS:    st_d = (k_q == n_ax) ? S_BWAIT : S_BP;
			S_BWAIT: st_d = S_BB;
			S_BB:    st_d = (k_q == n_ax) ? S_AXNEXT : S_BB;
			S_AXNEXT: begin
				if (ax_q == 2'd2) st_d = S_VW;
				else if (n_next == '0) st_d = S_BWAIT;
				else st_d = S_BP;
			end
			S_TF:     st_d = (k_q == K_W'(3)) ? S_TFWAIT : S_TF;
			S_TFWAIT: st_d = S_WT;
			S_VW:     st_d = S_VWWAIT;
			S_VWWAIT: st_d = S_WT;
			S_WT:     st_d = S_WTWAIT;
			S_WTWAIT: st_d = S_MX;
			S_MX:     st_d = S_MY;
			S_MY:     st_d = S_MZ;
			S_MZ: begin
				if (cfg.trilinear) st_d = (idx_q == IDX_W'(7)) ? S_DRAIN : S_WT;
				else if (ku_q != nu) st_d = S_WT;
				else if (kv_q == nv && kw_q == nw) st_d = S_DRAIN;
				else st_d = S_VW;
			end
			S_DRAIN: st_d = S_OUT;
			S_OUT: begin
				if (!m_valid || m_ready) st_d = S_IDLE;
			end
			default: st_d = S_IDLE;
		endcase
	end

	// multiplier operands and queue pop
	always_comb begin
		q_pop   = 1'b0;
		mul_a   = '0;
		mul_b   = '0;
		mul_tag = T_NONE;
		mul_c   = 2'd1;
		unique case (st_q)
			S_IDLE: q_pop = q_valid;
			S_BP: begin
				mul_a   = MW'(pt_q[k_q - K_W'(1)]);
				mul_b   = t_ax;
				mul_tag = T_PT;
			end
			S_BS: begin
				mul_a   = MW'(ps_q[k_q - K_W'(1)]);
				mul_b   = s_ax;
				mul_tag = T_PS;
			end
			S_BB: begin
				mul_a   = MW'(pt_q[k_q]);
				mul_b   = ps_q[n_ax - k_q];
				mul_tag = T_B;
				mul_c   = binom(n_ax, k_q);
			end
			S_TF: begin
				case (k_q)
					2'd0: begin
						mul_a = MW'(su);
						mul_b = sv;
					end
					2'd1: begin
						mul_a = MW'(su);
						mul_b = v24;
					end
					2'd2: begin
						mul_a = MW'(u24);
						mul_b = v24;
					end
					default: begin
						mul_a = MW'(u24);
						mul_b = sv;
					end
				endcase
				mul_tag = T_F;
			end
			S_VW: begin
				mul_a   = MW'(b_q[2][kw_q]);
				mul_b   = b_q[1][kv_q];
				mul_tag = T_WVW;
			end
			S_WT: begin
				if (cfg.trilinear) begin
					mul_a = MW'(f_q[idx_q[1:0]]);
					mul_b = idx_q[2] ? w24 : sw;
				end else begin
					mul_a = MW'(wvw_q);
					mul_b = b_q[0][ku_q];
				end
				mul_tag = T_WT;
			end
			S_MX: begin
				mul_a   = MW'($signed(rd_q[CW-1:0]));
				mul_b   = wt_q;
				mul_tag = T_AX;
			end
			S_MY: begin
				mul_a   = MW'($signed(rd_q[CW +: CW]));
				mul_b   = wt_q;
				mul_tag = T_AY;
			end
			S_MZ: begin
				mul_a   = MW'($signed(rd_q[2 * CW +: CW]));
				mul_b   = wt_q;
				mul_tag = T_AZ;
			end
			default: ;
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// rounding of the registered product, Q16 half up
	assign rnd_w = (prod_q + P_HALF) >>> Q_FRAC;
	assign rnd_b = BW'(rnd_w);
	assign b_val = BW'(rnd_b * $signed({1'b0, tc_q}));

	// final rounding and saturation of the three sums
	always_comb begin
		logic signed [AW-1:0] rsh;
		for (int c = 0; c < 3; c++) begin
			rsh = (acc_q[c] + A_HALF) >>> Q_FRAC;
			if (&rsh[AW-1:CW-1] || ~|rsh[AW-1:CW-1]) begin
				fin[c * CW +: CW] = rsh[CW-1:0];
			end else if (rsh[AW-1]) begin
				fin[c * CW +: CW] = {1'b1, {(CW - 1){1'b0}}};
			end else begin
				fin[c * CW +: CW] = {1'b0, {(CW - 1){1'b1}}};
			end
		end
	end

	// lattice store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (st_q == S_LOAD && cls_q.cmd == CMD_WRITE) begin
			lat_mem[cls_q.idx] <= pt3_q;
		end
		rd_q <= lat_mem[idx_q];
	end

	// datapath
	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		tk_q   <= k_q;
		tax_q  <= ax_q;
		tc_q   <= mul_c;
		if (q_pop) begin
			cls_q <= q_cls;
			u_q   <= $signed(q_par[PAR_W-1:0]);
			v_q   <= $signed(q_par[PAR_W +: PAR_W]);
			w_q   <= $signed(q_par[2 * PAR_W +: PAR_W]);
			pt3_q <= q_pt;
		end
		if (st_q == S_LOAD) begin
			pt_q[0] <= Q_ONE;
			ps_q[0] <= Q_ONE;
			for (int c = 0; c < 3; c++) begin
				acc_q[c] <= '0;
			end
		end
		// product writeback by tag
		case (tag_q)
			T_PT:  pt_q[tk_q] <= rnd_b;
			T_PS:  ps_q[tk_q] <= rnd_b;
			T_B:   b_q[tax_q][tk_q] <= b_val;
			T_F:   f_q[tk_q] <= rnd_b;
			T_WVW: wvw_q <= rnd_b;
			T_WT:  wt_q <= rnd_b;
			T_AX:  acc_q[0] <= acc_q[0] + AW'(prod_q);
			T_AY:  acc_q[1] <= acc_q[1] + AW'(prod_q);
			T_AZ:  acc_q[2] <= acc_q[2] + AW'(prod_q);
			default: ;
		endcase
		if (out_load) begin
			m_data     <= cls_q.in_cube ? fin : pt3_q;
			m_deformed <= cls_q.in_cube;
			m_last     <= cls_q.last;
		end
	end

	// sequencer state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= S_IDLE;
			tag_q   <= T_NONE;
			ax_q    <= 2'd0;
			k_q     <= '0;
			ku_q    <= '0;
			kv_q    <= '0;
			kw_q    <= '0;
			idx_q   <= '0;
			m_valid <= 1'b0;
		end else begin
			st_q  <= st_d;
			tag_q <= mul_tag;
			unique case (st_q)
				S_LOAD: begin
					ax_q  <= 2'd0;
					k_q   <= cfg.trilinear ? K_W'(0) : K_W'(1);
					ku_q  <= '0;
					kv_q  <= '0;
					kw_q  <= '0;
					idx_q <= '0;
				end
				S_BS: begin
					if (k_q != n_ax) k_q <= k_q + K_W'(1);
				end
				S_BWAIT: k_q <= '0;
				S_BB: begin
					if (k_q != n_ax) k_q <= k_q + K_W'(1);
				end
				S_AXNEXT: begin
					if (ax_q != 2'd2) begin
						ax_q <= ax_q + 2'd1;
						k_q  <= K_W'(1);
					end
				end
				S_TF: k_q <= k_q + K_W'(1);
				S_MZ: begin
					idx_q <= idx_q + IDX_W'(1);
					if (ku_q != nu) begin
						ku_q <= ku_q + K_W'(1);
					end else begin
						ku_q <= '0;
						if (kv_q != nv) begin
							kv_q <= kv_q + K_W'(1);
						end else begin
							kv_q <= '0;
							kw_q <= kw_q + K_W'(1);
						end
					end
				end
				default: ;
			endcase
			if (out_load) begin
				m_valid <= 1'b1;
			end else if (m_ready) begin
				m_valid <= 1'b0;
			end
		end
	end

endmodule

FILE: design/bezier_lattice_point_deform_top.sv
// ----------------------------------------------------------------------------
// bezier_lattice_point_deform_top
// Free-form deformation of points by a Bezier or trilinear control lattice.
// ----------------------------------------------------------------------------
// A word with tuser 0 stores one control point at lattice_index and returns
// nothing; a word with tuser 1 evaluates one point and returns one word. Words
// are taken into a two-entry queue and carried out one at a time by a
// sequencer around a single shared multiplier, so the rate is set by the
// number of products. Writes and points outside the unit cube use no
// products; a Bernstein evaluation needs more of them as the orders nu, nv,
// nw grow. The result register lets the next word enter the queue while a
// result waits on m_tready. Orders and mode must be written through the cfg
// port only while the block is idle; the block itself does not enforce this.
module bezier_lattice_point_deform_top #(
	parameter int COORD_WIDTH = 32,
	localparam int IN_W  = ((6 + 6 * COORD_WIDTH + 3 * 19) + 7) / 8 * 8,
	localparam int OUT_W = (3 * COORD_WIDTH + 7) / 8 * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	// lattice_index, ctrl_x, ctrl_y, ctrl_z, param_u, param_v, param_w,
	// orig_x, orig_y, orig_z, zero fill
	input  logic [IN_W-1:0]  s_tdata,
	// command
	input  logic             s_tuser,
	input  logic             s_tlast,
	output logic             m_tvalid,
	input  logic             m_tready,
	// out_x, out_y, out_z, zero fill
	output logic [OUT_W-1:0] m_tdata,
	// deformed
	output logic             m_tuser,
	output logic             m_tlast,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [2:0]       cfg_data
);
	import blpd_pkg::*;

	localparam int CW = COORD_WIDTH;

	cfg_t                 cfg_q;
	logic                 q_valid, q_pop;
	cls_t                 q_cls;
	logic [3*PAR_W-1:0]   q_par;
	logic [3*CW-1:0]      q_pt;
	logic [3*CW-1:0]      m_data;

	// configuration registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.order_u   <= 3'd2;
			cfg_q.order_v   <= 3'd2;
			cfg_q.order_w   <= 3'd2;
			cfg_q.trilinear <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_ORDER_U:   cfg_q.order_u   <= cfg_data;
				CFG_ORDER_V:   cfg_q.order_v   <= cfg_data;
				CFG_ORDER_W:   cfg_q.order_w   <= cfg_data;
				CFG_TRILINEAR: cfg_q.trilinear <= cfg_data[0];
				default: ;
			endcase
		end
	end

	blpd_front #(.CW(CW)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_tvalid),
		.s_ready (s_tready),
		.s_data  (s_tdata),
		.s_cmd   (s_tuser),
		.s_last  (s_tlast),
		.q_valid (q_valid),
		.q_pop   (q_pop),
		.q_cls   (q_cls),
		.q_par   (q_par),
		.q_pt    (q_pt)
	);

	blpd_back #(.CW(CW)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.q_valid    (q_valid),
		.q_pop      (q_pop),
		.q_cls      (q_cls),
		.q_par      (q_par),
		.q_pt       (q_pt),
		.m_valid    (m_tvalid),
		.m_ready    (m_tready),
		.m_data     (m_data),
		.m_deformed (m_tuser),
		.m_last     (m_tlast)
	);

	assign m_tdata = OUT_W'(m_data);

endmodule

FILE: design/blpd_chk.sv
// ----------------------------------------------------------------------------
// blpd_chk
// Port-level checks of the deformation block, bound to its top level.
// ----------------------------------------------------------------------------
module blpd_chk #(
	parameter int COORD_WIDTH = 32,
	localparam int OUT_W = (3 * COORD_WIDTH + 7) / 8 * 8
) (
	input logic             clk,
	input logic             arst_n,
	input logic             s_tvalid,
	input logic             s_tready,
	input logic             s_tuser,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata,
	input logic             m_tuser,
	input logic             m_tlast
);
	logic [3:0] pend_q;
	logic       eval_in, word_out;

	assign eval_in  = s_tvalid && s_tready && s_tuser;
	assign word_out = m_tvalid && m_tready;

	// evaluate words taken but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 4'd0;
		end else if (eval_in && !word_out) begin
			pend_q <= pend_q + 4'd1;
		end else if (!eval_in && word_out) begin
			pend_q <= pend_q - 4'd1;
		end
	end

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
		$stable(m_tlast))
		else $error("result word changed while stalled");

	// every result answers an earlier evaluate word
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		word_out |-> pend_q != 4'd0)
		else $error("result word without a pending evaluate");

	// queue, sequencer and result register hold at most four words
	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		eval_in |-> pend_q <= 4'd3)
		else $error("more evaluate words taken than the block can hold");

endmodule

bind bezier_lattice_point_deform_top blpd_chk #(.COORD_WIDTH(COORD_WIDTH)) u_blpd_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

FILE: bench/blpd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blpd_checker
// Watches the input, output and register channels of the lattice deformation
// block, predicts every result word and compares it field by field.
// ----------------------------------------------------------------------------
module blpd_checker
	import blpd_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [255:0] s_tdata,
	input  logic         s_tuser,
	input  logic         s_tlast,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [95:0]  m_tdata,
	input  logic         m_tuser,
	input  logic         m_tlast,
	input  logic         cfg_valid,
	input  logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [2:0]   cfg_data,
	output int           errors,
	output int           pending
);

	typedef struct {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic        deformed;
		logic        last;
	} point_t;

	point_t      expected_points[$];
	logic [31:0] lattice_copy[64][3];
	logic [2:0]  ord_u, ord_v, ord_w;
	logic        trilin;
	longint      basis_w[3][4];

	assign pending = expected_points.size();

	// Q16 product rounding, half up
	function automatic longint rnd16(input longint p);
		return (p + 64'sd32768) >>> 16;
	endfunction

	function automatic int axis_n(input logic [2:0] o);
		int e;
		e = (o == 3'd0) ? 1 : (o > 3'd4) ? 4 : int'(o);
		return e - 1;
	endfunction

	// Bernstein weights of one axis, degree n
	function automatic void fill_basis(input int axis, input longint t, input int n);
		longint pt[4];
		longint ps[4];
		longint s;
		longint c;
		s = 64'sd65536 - t;
		pt[0] = 65536;
		ps[0] = 65536;
		for (int k = 1; k <= n; k++) begin
			pt[k] = rnd16(pt[k-1] * t);
			ps[k] = rnd16(ps[k-1] * s);
		end
		for (int k = 0; k <= n; k++) begin
			c = 1;
			if (k != 0 && k != n)
				c = (n == 3) ? 3 : 2;
			basis_w[axis][k] = c * rnd16(pt[k] * ps[n-k]);
		end
	endfunction

	function automatic logic [31:0] finish_coord(input longint a);
		longint r;
		r = (a + 64'sd32768) >>> 16;
		if (r > 64'sd2147483647)
			r = 64'sd2147483647;
		if (r < -64'sd2147483648)
			r = -64'sd2147483648;
		return r[31:0];
	endfunction

	// expected word for one accepted evaluate word
	function automatic point_t deform_point(input logic [255:0] d, input logic last);
		point_t p;
		longint u, v, w, wt, wvw;
		longint acc[3];
		longint f[4];
		int nu, nv, nw, idx;
		u = longint'($signed(d[120:102]));
		v = longint'($signed(d[139:121]));
		w = longint'($signed(d[158:140]));
		p.last = last;
		if (!(u >= -1 && u <= 65537 && v >= -1 && v <= 65537 && w >= -1 && w <= 65537)) begin
			p.x = d[190:159];
			p.y = d[222:191];
			p.z = d[254:223];
			p.deformed = 1'b0;
			return p;
		end
		acc[0] = 0;
		acc[1] = 0;
		acc[2] = 0;
		if (trilin) begin
			f[0] = rnd16((65536 - u) * (65536 - v));
			f[1] = rnd16((65536 - u) * v);
			f[2] = rnd16(u * v);
			f[3] = rnd16(u * (65536 - v));
			for (int i = 0; i < 8; i++) begin
				wt = rnd16(f[i % 4] * ((i < 4) ? (65536 - w) : w));
				for (int c = 0; c < 3; c++)
					acc[c] += longint'($signed(lattice_copy[i][c])) * wt;
			end
		end else begin
			nu = axis_n(ord_u);
			nv = axis_n(ord_v);
			nw = axis_n(ord_w);
			fill_basis(0, u, nu);
			fill_basis(1, v, nv);
			fill_basis(2, w, nw);
			for (int kw = 0; kw <= nw; kw++)
				for (int kv = 0; kv <= nv; kv++) begin
					wvw = rnd16(basis_w[2][kw] * basis_w[1][kv]);
					for (int ku = 0; ku <= nu; ku++) begin
						wt = rnd16(wvw * basis_w[0][ku]);
						idx = (kw * (nv + 1) + kv) * (nu + 1) + ku;
						for (int c = 0; c < 3; c++)
							acc[c] += longint'($signed(lattice_copy[idx][c])) * wt;
					end
				end
		end
		p.x = finish_coord(acc[0]);
		p.y = finish_coord(acc[1]);
		p.z = finish_coord(acc[2]);
		p.deformed = 1'b1;
		return p;
	endfunction

	// channel monitor
	always @(posedge clk or negedge arst_n) begin
		point_t e;
		if (!arst_n) begin
			expected_points.delete();
			ord_u  <= 3'd2;
			ord_v  <= 3'd2;
			ord_w  <= 3'd2;
			trilin <= 1'b0;
			errors <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					CFG_ORDER_U:   ord_u  <= cfg_data;
					CFG_ORDER_V:   ord_v  <= cfg_data;
					CFG_ORDER_W:   ord_w  <= cfg_data;
					CFG_TRILINEAR: trilin <= cfg_data[0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				if (cmd_t'(s_tuser) == CMD_WRITE) begin
					lattice_copy[s_tdata[5:0]][0] = s_tdata[37:6];
					lattice_copy[s_tdata[5:0]][1] = s_tdata[69:38];
					lattice_copy[s_tdata[5:0]][2] = s_tdata[101:70];
				end else begin
					expected_points.push_back(deform_point(s_tdata, s_tlast));
				end
			end
			if (m_tvalid && m_tready) begin
				if (expected_points.size() == 0) begin
					if (errors < 10)
						$display("unexpected result word: %h user %b last %b",
							m_tdata, m_tuser, m_tlast);
					errors <= errors + 1;
				end else begin
					e = expected_points.pop_front();
					if (m_tdata[31:0] !== e.x || m_tdata[63:32] !== e.y ||
						m_tdata[95:64] !== e.z || m_tuser !== e.deformed ||
						m_tlast !== e.last) begin
						if (errors < 10)
							$display("mismatch: exp %h %h %h d%b l%b, got %h %h %h d%b l%b",
								e.x, e.y, e.z, e.deformed, e.last, m_tdata[31:0],
								m_tdata[63:32], m_tdata[95:64], m_tuser, m_tlast);
						errors <= errors + 1;
					end
				end
			end
		end
	end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the lattice deformation block: fills the lattice,
// runs directed corner points, then random words under several orders and
// modes, with random stalls on both sides in the first four settings.
// ----------------------------------------------------------------------------
module tb_top;
	import blpd_pkg::*;

	localparam int WD_LIMIT = 20000;
	localparam int SETTLE   = 500;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [255:0] s_tdata = '0;
	logic         s_tuser = 1'b0;
	logic         s_tlast = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [95:0]  m_tdata;
	logic         m_tuser;
	logic         m_tlast;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [1:0]   cfg_index = '0;
	logic [2:0]   cfg_data = '0;
	int           errors;
	int           pending;
	int           send_idle = 26;
	int           recv_idle = 54;
	int           quiet_cycles = 0;

	always #5 clk = ~clk;

	bezier_lattice_point_deform_top i_dut (.*);

	blpd_checker i_checker (.*);

	// receiver stalls
	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= recv_idle);

	// watchdog on cycles with no accepted word
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WD_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic logic [255:0] pack_word(input logic [5:0] idx,
		input logic [31:0] cx, input logic [31:0] cy, input logic [31:0] cz,
		input logic [18:0] u, input logic [18:0] v, input logic [18:0] w,
		input logic [31:0] ox, input logic [31:0] oy, input logic [31:0] oz);
		return {1'b0, oz, oy, ox, w, v, u, cz, cy, cx, idx};
	endfunction

	// called at a falling edge, returns at a falling edge
	task automatic send_word(input logic [255:0] d, input cmd_t cmd, input logic last);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= d;
		s_tuser  <= cmd;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [2:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// wait until every result is back and a write may still be finishing
	task automatic drain();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(7))
			0:       return 32'h7fffffff;
			1:       return 32'h80000000;
			default: return $urandom;
		endcase
	endfunction

	// mostly inside the unit cube, some near its faces, some anywhere
	function automatic logic [18:0] rand_param();
		int r;
		r = $urandom_range(9);
		if (r < 7)
			return 19'($urandom_range(65536));
		if (r == 7) begin
			case ($urandom_range(3))
				0: return -19'sd1;
				1: return 19'sd65537;
				2: return -19'sd2;
				default: return 19'sd65538;
			endcase
		end
		if (r == 8)
			return ($urandom_range(1)) ? 19'h3ffff : 19'h40000;
		return 19'($urandom);
	endfunction

	task automatic send_eval(input logic [18:0] u, input logic [18:0] v, input logic [18:0] w);
		send_word(pack_word(6'($urandom), $urandom, $urandom, $urandom, u, v, w,
			rand_coord(), rand_coord(), rand_coord()), CMD_EVAL, 1'($urandom));
	endtask

	task automatic send_ctrl(input logic [5:0] idx, input logic [31:0] x,
		input logic [31:0] y, input logic [31:0] z);
		send_word(pack_word(idx, x, y, z, 19'($urandom), 19'($urandom), 19'($urandom),
			$urandom, $urandom, $urandom), CMD_WRITE, 1'($urandom));
	endtask

	logic [2:0] seg_cfg[6][4] = '{
		'{3'd1, 3'd4, 3'd3, 3'd0},
		'{3'd4, 3'd4, 3'd4, 3'd0},
		'{3'd0, 3'd7, 3'd5, 3'd1},
		'{3'd2, 3'd3, 3'd1, 3'd0},
		'{3'd3, 3'd2, 3'd0, 3'd1},
		'{3'd6, 3'd1, 3'd2, 3'd0}
	};

	initial begin
		logic [18:0] corners[8];
		corners = '{19'sd0, 19'sd65536, -19'sd1, 19'sd65537, 19'sd32768,
			-19'sd2, 19'sd65538, 19'h40000};
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// whole lattice written before any read
		for (int i = 0; i < 64; i++)
			send_ctrl(6'(i), rand_coord(), rand_coord(), rand_coord());

		// directed corners of the parameter range
		for (int i = 0; i < 8; i++)
			send_eval(corners[i], corners[(i + 3) % 8], corners[(i + 5) % 8]);
		send_eval(19'h3ffff, 19'sd0, 19'sd0);
		// saturation: extreme corners, weights pushed past one
		for (int i = 0; i < 8; i++)
			send_ctrl(6'(i), 32'h7fffffff, 32'h80000000, (i < 4) ? 32'hffffffff : 32'h7fffffff);
		send_eval(19'sd65537, 19'sd65537, 19'sd65537);
		send_eval(-19'sd1, -19'sd1, -19'sd1);
		send_eval(19'sd32768, 19'sd32768, 19'sd65537);
		drain();

		// random words under each setting
		for (int seg = 0; seg < 6; seg++) begin
			write_reg(CFG_ORDER_U, seg_cfg[seg][0]);
			write_reg(CFG_ORDER_V, seg_cfg[seg][1]);
			write_reg(CFG_ORDER_W, seg_cfg[seg][2]);
			write_reg(CFG_TRILINEAR, seg_cfg[seg][3]);
			send_idle = (seg < 2) ? 26 : (seg < 4) ? 54 : 0;
			recv_idle = (seg < 2) ? 54 : (seg < 4) ? 26 : 0;
			for (int n = 0; n < 111; n++) begin
				if ($urandom_range(3) == 0)
					send_ctrl(6'($urandom), rand_coord(), rand_coord(), rand_coord());
				else
					send_eval(rand_param(), rand_param(), rand_param());
			end
			drain();
		end

		if (errors == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
